@@ design/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// tfn_pkg
// types and constants shared by the triangle face normal pipeline
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_W  = 24;
    localparam int NORMAL_W = 16;

    localparam int PRE      = (COORD_W > 30) ? COORD_W - 30 : 0;
    localparam int EDGE_W   = COORD_W + 1 - PRE;
    localparam int PROD_W   = 2 * EDGE_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int LPOS_W   = $clog2(CROSS_W);
    localparam int TARGET   = 29;
    localparam int MAG_W    = 31;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = 31;
    localparam int FRAC_W   = NORMAL_W - 2;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int REM_W    = MAG_W + FRAC_W + 1;
    localparam int SSIDE_W  = 3 + 3 * MAG_W + 2;
    localparam int DSIDE_W  = 3 + 2 + ROOT_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
        logic                      end_of_mesh;
    } tri_item_t;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] normal_x;
        logic signed [NORMAL_W-1:0] normal_y;
        logic signed [NORMAL_W-1:0] normal_z;
        logic                       degenerate;
        logic                       end_of_mesh_out;
    } norm_item_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } step_t;

endpackage

@@ design/tfn_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// tfn_sqrt_cell
// one root bit of the restoring integer square root chain
// ----------------------------------------------------------------------------
module tfn_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tfn_pkg::step_t              step_in,
    input  logic [tfn_pkg::SUM_W-1:0]   rem_in,
    input  logic [tfn_pkg::ROOT_W-1:0]  root_in,
    input  logic [tfn_pkg::SSIDE_W-1:0] side_in,
    output logic                        valid_out,
    output logic [tfn_pkg::SUM_W-1:0]   rem_out,
    output logic [tfn_pkg::ROOT_W-1:0]  root_out,
    output logic [tfn_pkg::SSIDE_W-1:0] side_out
);

    logic [tfn_pkg::SUM_W-1:0]   trial;
    logic [tfn_pkg::SUM_W-1:0]   rem_next;
    logic [tfn_pkg::ROOT_W-1:0]  root_next;
    logic                        valid_reg;
    logic [tfn_pkg::SUM_W-1:0]   rem_reg;
    logic [tfn_pkg::ROOT_W-1:0]  root_reg;
    logic [tfn_pkg::SSIDE_W-1:0] side_reg;

    always_comb
    begin
        trial = (tfn_pkg::SUM_W'(root_in) << (BIT + 1))
              + (tfn_pkg::SUM_W'(1) << (2 * BIT));
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = root_in | (tfn_pkg::ROOT_W'(1) << BIT);
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step_in.advance)
        begin
            valid_reg <= step_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_in.advance)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

@@ design/tfn_div_cell.sv @@
// ----------------------------------------------------------------------------
// tfn_div_cell
// one quotient bit of the three-lane restoring division chain
// ----------------------------------------------------------------------------
module tfn_div_cell #(
    parameter int BIT = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tfn_pkg::step_t              step_in,
    input  logic [tfn_pkg::REM_W-1:0]   rem_in [3],
    input  logic [tfn_pkg::QUO_W-1:0]   quo_in [3],
    input  logic [tfn_pkg::DSIDE_W-1:0] side_in,
    output logic                        valid_out,
    output logic [tfn_pkg::REM_W-1:0]   rem_out [3],
    output logic [tfn_pkg::QUO_W-1:0]   quo_out [3],
    output logic [tfn_pkg::DSIDE_W-1:0] side_out
);

    logic [tfn_pkg::REM_W-1:0]   divisor;
    logic [tfn_pkg::REM_W-1:0]   rem_next [3];
    logic [tfn_pkg::QUO_W-1:0]   quo_next [3];
    logic                        valid_reg;
    logic [tfn_pkg::REM_W-1:0]   rem_reg [3];
    logic [tfn_pkg::QUO_W-1:0]   quo_reg [3];
    logic [tfn_pkg::DSIDE_W-1:0] side_reg;

    always_comb
    begin
        divisor = tfn_pkg::REM_W'(side_in[tfn_pkg::ROOT_W-1:0]) << BIT;
        for (int i = 0; i < 3; i++)
        begin
            if (rem_in[i] >= divisor)
            begin
                rem_next[i] = rem_in[i] - divisor;
                quo_next[i] = quo_in[i] | (tfn_pkg::QUO_W'(1) << BIT);
            end
            else
            begin
                rem_next[i] = rem_in[i];
                quo_next[i] = quo_in[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step_in.advance)
        begin
            valid_reg <= step_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_in.advance)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign side_out  = side_reg;

endmodule

@@ design/triangle_face_normal.sv @@
// ----------------------------------------------------------------------------
// triangle_face_normal
// unit face normal of a triangle, pipelined with one triangle per cycle
// ----------------------------------------------------------------------------
// tri channel carries one triangle (three Q7.16 vertices and an end-of-mesh
// mark); norm channel returns its unit normal in Q1.14 with a degenerate flag.
// both channels transfer on valid and ready high at a rising edge.
// throughput: one triangle per cycle unless the output buffer is full. a result
// passes from tri transfer to norm valid through the front stages, the
// root chain (one cell per root bit), the numerator register, the division
// chain (one cell per quotient bit, three lanes each) and the output buffer.
// when the receiver stalls, a two-entry output buffer absorbs the result
// in flight; once both entries are full the pipeline freezes and tri_ready
// drops until norm takes a result.
// reset clears all valid bits and the output buffer; tri_ready is high as
// soon as reset is released.
// a zero cross product gives a zero normal with degenerate set.
// ----------------------------------------------------------------------------
module triangle_face_normal (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tri_valid,
    output logic                tri_ready,
    input  tfn_pkg::tri_item_t  tri_data,
    output logic                norm_valid,
    input  logic                norm_ready,
    output tfn_pkg::norm_item_t norm_data
);

    localparam int EW = tfn_pkg::EDGE_W;
    localparam int CW = tfn_pkg::CROSS_W;
    localparam int MW = tfn_pkg::MAG_W;
    localparam int NW = tfn_pkg::NORMAL_W;

    logic advance;

    // edge vectors
    logic signed [tfn_pkg::COORD_W:0] da [3];
    logic signed [tfn_pkg::COORD_W:0] db [3];
    logic signed [EW-1:0] u_reg [3];
    logic signed [EW-1:0] v_reg [3];
    logic                 eom1_reg;
    logic                 v1_reg;

    always_comb
    begin
        da[0] = ((tfn_pkg::COORD_W + 1)'(tri_data.second_x)
              - (tfn_pkg::COORD_W + 1)'(tri_data.first_x)) >>> tfn_pkg::PRE;
        da[1] = ((tfn_pkg::COORD_W + 1)'(tri_data.second_y)
              - (tfn_pkg::COORD_W + 1)'(tri_data.first_y)) >>> tfn_pkg::PRE;
        da[2] = ((tfn_pkg::COORD_W + 1)'(tri_data.second_z)
              - (tfn_pkg::COORD_W + 1)'(tri_data.first_z)) >>> tfn_pkg::PRE;
        db[0] = ((tfn_pkg::COORD_W + 1)'(tri_data.third_x)
              - (tfn_pkg::COORD_W + 1)'(tri_data.first_x)) >>> tfn_pkg::PRE;
        db[1] = ((tfn_pkg::COORD_W + 1)'(tri_data.third_y)
              - (tfn_pkg::COORD_W + 1)'(tri_data.first_y)) >>> tfn_pkg::PRE;
        db[2] = ((tfn_pkg::COORD_W + 1)'(tri_data.third_z)
              - (tfn_pkg::COORD_W + 1)'(tri_data.first_z)) >>> tfn_pkg::PRE;
    end

    // products
    logic signed [tfn_pkg::PROD_W-1:0] p_reg [6];
    logic eom2_reg;
    logic v2_reg;

    // cross product
    logic signed [CW-1:0] n3_reg [3];
    logic eom3_reg;
    logic v3_reg;

    // leading one detect
    logic [CW-1:0]             amag [3];
    logic [CW-1:0]             any_bits;
    logic [tfn_pkg::LPOS_W-1:0] lpos;
    logic signed [CW-1:0]      n4_reg [3];
    logic [tfn_pkg::LPOS_W-1:0] amt4_reg;
    logic                      down4_reg;
    logic                      deg4_reg;
    logic                      eom4_reg;
    logic                      v4_reg;

    always_comb
    begin
        lpos = '0;
        for (int i = 0; i < 3; i++)
        begin
            amag[i] = n3_reg[i][CW-1] ? CW'(-n3_reg[i]) : CW'(n3_reg[i]);
        end
        any_bits = amag[0] | amag[1] | amag[2];
        for (int k = 0; k < CW; k++)
        begin
            if (any_bits[k])
            begin
                lpos = tfn_pkg::LPOS_W'(k);
            end
        end
    end

    // block scaling
    logic signed [CW-1:0] sc [3];
    logic [MW-1:0]        mag5_reg [3];
    logic [2:0]           sgn5_reg;
    logic                 deg5_reg;
    logic                 eom5_reg;
    logic                 v5_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sc[i] = down4_reg ? (n4_reg[i] >>> amt4_reg) : (n4_reg[i] <<< amt4_reg);
        end
    end

    // squares
    logic [tfn_pkg::SQ_W-1:0] sq6_reg [3];
    logic [MW-1:0]            mag6_reg [3];
    logic [2:0]               sgn6_reg;
    logic                     deg6_reg;
    logic                     eom6_reg;
    logic                     v6_reg;

    // sum
    logic [tfn_pkg::SUM_W-1:0] sum7_reg;
    logic [MW-1:0]             mag7_reg [3];
    logic [2:0]                sgn7_reg;
    logic                      deg7_reg;
    logic                      eom7_reg;
    logic                      v7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= tri_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= da[i][EW-1:0];
                v_reg[i] <= db[i][EW-1:0];
            end
            eom1_reg <= tri_data.end_of_mesh;

            p_reg[0] <= u_reg[1] * v_reg[2];
            p_reg[1] <= u_reg[2] * v_reg[1];
            p_reg[2] <= u_reg[2] * v_reg[0];
            p_reg[3] <= u_reg[0] * v_reg[2];
            p_reg[4] <= u_reg[0] * v_reg[1];
            p_reg[5] <= u_reg[1] * v_reg[0];
            eom2_reg <= eom1_reg;

            for (int i = 0; i < 3; i++)
            begin
                n3_reg[i] <= CW'(p_reg[2 * i]) - CW'(p_reg[2 * i + 1]);
            end
            eom3_reg <= eom2_reg;

            n4_reg    <= n3_reg;
            down4_reg <= (lpos > tfn_pkg::LPOS_W'(tfn_pkg::TARGET));
            amt4_reg  <= (lpos > tfn_pkg::LPOS_W'(tfn_pkg::TARGET))
                       ? lpos - tfn_pkg::LPOS_W'(tfn_pkg::TARGET)
                       : tfn_pkg::LPOS_W'(tfn_pkg::TARGET) - lpos;
            deg4_reg  <= (any_bits == '0);
            eom4_reg  <= eom3_reg;

            for (int i = 0; i < 3; i++)
            begin
                sgn5_reg[i] <= sc[i][CW-1];
                mag5_reg[i] <= sc[i][CW-1] ? MW'(-sc[i]) : MW'(sc[i]);
            end
            deg5_reg <= deg4_reg;
            eom5_reg <= eom4_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq6_reg[i] <= tfn_pkg::SQ_W'(mag5_reg[i]) * tfn_pkg::SQ_W'(mag5_reg[i]);
            end
            mag6_reg <= mag5_reg;
            sgn6_reg <= sgn5_reg;
            deg6_reg <= deg5_reg;
            eom6_reg <= eom5_reg;

            sum7_reg <= tfn_pkg::SUM_W'(sq6_reg[0]) + tfn_pkg::SUM_W'(sq6_reg[1])
                      + tfn_pkg::SUM_W'(sq6_reg[2]);
            mag7_reg <= mag6_reg;
            sgn7_reg <= sgn6_reg;
            deg7_reg <= deg6_reg;
            eom7_reg <= eom6_reg;
        end
    end

    // square root chain
    logic [tfn_pkg::SUM_W-1:0]   sq_rem  [tfn_pkg::ROOT_W+1];
    logic [tfn_pkg::ROOT_W-1:0]  sq_root [tfn_pkg::ROOT_W+1];
    logic [tfn_pkg::SSIDE_W-1:0] sq_side [tfn_pkg::ROOT_W+1];
    logic                        sq_valid [tfn_pkg::ROOT_W+1];

    assign sq_rem[0]   = sum7_reg;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {sgn7_reg, mag7_reg[0], mag7_reg[1], mag7_reg[2], deg7_reg, eom7_reg};
    assign sq_valid[0] = v7_reg;

    for (genvar k = 0; k < tfn_pkg::ROOT_W; k++)
    begin : g_sqrt
        tfn_pkg::step_t step;
        assign step.valid   = sq_valid[k];
        assign step.advance = advance;
        tfn_sqrt_cell #(
            .BIT(tfn_pkg::ROOT_W - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .step_in  (step),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .side_in  (sq_side[k]),
            .valid_out(sq_valid[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1]),
            .side_out (sq_side[k+1])
        );
    end

    // numerator with rounding term
    logic [tfn_pkg::SSIDE_W-1:0] sq_last;
    logic [MW-1:0]               smag [3];
    logic [tfn_pkg::REM_W-1:0]   num_reg [3];
    logic [tfn_pkg::DSIDE_W-1:0] nside_reg;
    logic                        vn_reg;

    assign sq_last = sq_side[tfn_pkg::ROOT_W];
    assign smag[0] = sq_last[2 + 3 * MW - 1 : 2 + 2 * MW];
    assign smag[1] = sq_last[2 + 2 * MW - 1 : 2 + MW];
    assign smag[2] = sq_last[2 + MW - 1 : 2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg <= 1'b0;
        end
        else if (advance)
        begin
            vn_reg <= sq_valid[tfn_pkg::ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= (tfn_pkg::REM_W'(smag[i]) << tfn_pkg::FRAC_W)
                            + tfn_pkg::REM_W'(sq_root[tfn_pkg::ROOT_W] >> 1);
            end
            nside_reg <= {sq_last[tfn_pkg::SSIDE_W-1 -: 3], sq_last[1:0],
                          sq_root[tfn_pkg::ROOT_W]};
        end
    end

    // division chain
    logic [tfn_pkg::REM_W-1:0]   dv_rem  [tfn_pkg::QUO_W+1][3];
    logic [tfn_pkg::QUO_W-1:0]   dv_quo  [tfn_pkg::QUO_W+1][3];
    logic [tfn_pkg::DSIDE_W-1:0] dv_side [tfn_pkg::QUO_W+1];
    logic                        dv_valid [tfn_pkg::QUO_W+1];

    assign dv_rem[0]   = num_reg;
    assign dv_quo[0]   = '{default: '0};
    assign dv_side[0]  = nside_reg;
    assign dv_valid[0] = vn_reg;

    for (genvar k = 0; k < tfn_pkg::QUO_W; k++)
    begin : g_div
        tfn_pkg::step_t step;
        assign step.valid   = dv_valid[k];
        assign step.advance = advance;
        tfn_div_cell #(
            .BIT(tfn_pkg::QUO_W - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .step_in  (step),
            .rem_in   (dv_rem[k]),
            .quo_in   (dv_quo[k]),
            .side_in  (dv_side[k]),
            .valid_out(dv_valid[k+1]),
            .rem_out  (dv_rem[k+1]),
            .quo_out  (dv_quo[k+1]),
            .side_out (dv_side[k+1])
        );
    end

    // result assembly
    logic [tfn_pkg::DSIDE_W-1:0] dlast;
    logic [2:0]                  dsgn;
    logic                        ddeg;
    logic signed [NW-1:0]        comp [3];
    tfn_pkg::norm_item_t         result;

    always_comb
    begin
        dlast = dv_side[tfn_pkg::QUO_W];
        dsgn  = dlast[tfn_pkg::DSIDE_W-1 -: 3];
        ddeg  = dlast[tfn_pkg::ROOT_W + 1];
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = NW'(dv_quo[tfn_pkg::QUO_W][i]);
            if (ddeg)
            begin
                comp[i] = '0;
            end
            else if (dsgn[i])
            begin
                comp[i] = -comp[i];
            end
        end
        result.normal_x        = comp[0];
        result.normal_y        = comp[1];
        result.normal_z        = comp[2];
        result.degenerate      = ddeg;
        result.end_of_mesh_out = dlast[tfn_pkg::ROOT_W];
    end

    // output buffer with skid entry
    logic                out_valid_reg;
    logic                out_valid_next;
    tfn_pkg::norm_item_t out_data_reg;
    tfn_pkg::norm_item_t out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    tfn_pkg::norm_item_t skid_data_reg;
    tfn_pkg::norm_item_t skid_data_next;
    logic                take;
    logic                arrive;

    assign advance = !skid_valid_reg;
    assign take    = out_valid_reg && norm_ready;
    assign arrive  = advance && dv_valid[tfn_pkg::QUO_W];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign tri_ready  = advance;
    assign norm_valid = out_valid_reg;
    assign norm_data  = out_data_reg;

endmodule

@@ tb/tb_triangle_face_normal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal
// randomized check of the triangle face normal pipeline
// ----------------------------------------------------------------------------
// drives triangles on the tri channel, predicts each unit normal with an
// independent fixed-point model and compares every norm transfer in order.
// runs through phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_triangle_face_normal;

    class normal_scoreboard;
        tfn_pkg::norm_item_t pending_normals[$];
        int errors;

        function automatic longint floor_shift(longint v, int s);
            if (s <= 0)
                return v;
            return v >>> s;
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic tfn_pkg::norm_item_t face_normal(tfn_pkg::tri_item_t t);
            longint a[3], b[3], c[3], u[3], v[3], n[3];
            longint unsigned m, mg, sum, len, q;
            int pre, up, down;
            tfn_pkg::norm_item_t r;
            pre = (tfn_pkg::COORD_W > 30) ? tfn_pkg::COORD_W - 30 : 0;
            a[0] = t.first_x;  a[1] = t.first_y;  a[2] = t.first_z;
            b[0] = t.second_x; b[1] = t.second_y; b[2] = t.second_z;
            c[0] = t.third_x;  c[1] = t.third_y;  c[2] = t.third_z;
            for (int i = 0; i < 3; i++)
            begin
                u[i] = floor_shift(b[i] - a[i], pre);
                v[i] = floor_shift(c[i] - a[i], pre);
            end
            n[0] = u[1] * v[2] - u[2] * v[1];
            n[1] = u[2] * v[0] - u[0] * v[2];
            n[2] = u[0] * v[1] - u[1] * v[0];
            r = '0;
            r.end_of_mesh_out = t.end_of_mesh;
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                mg = (n[i] < 0) ? -n[i] : n[i];
                if (mg > m)
                    m = mg;
            end
            if (m == 0)
            begin
                r.degenerate = 1'b1;
                return r;
            end
            up = 0;
            down = 0;
            while (m >= (64'd1 << 30))
            begin
                m = m >> 1;
                down++;
            end
            while (m < (64'd1 << 29))
            begin
                m = m << 1;
                up++;
            end
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                if (down > 0)
                    n[i] = n[i] >>> down;
                else
                    n[i] = n[i] <<< up;
                mg = (n[i] < 0) ? -n[i] : n[i];
                sum += mg * mg;
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                mg = (n[i] < 0) ? -n[i] : n[i];
                q = ((mg << tfn_pkg::FRAC_W) + len / 2) / len;
                if (i == 0)
                    r.normal_x = (n[i] < 0) ? -q : q;
                else if (i == 1)
                    r.normal_y = (n[i] < 0) ? -q : q;
                else
                    r.normal_z = (n[i] < 0) ? -q : q;
            end
            return r;
        endfunction

        function void note_triangle(tfn_pkg::tri_item_t t);
            pending_normals.push_back(face_normal(t));
        endfunction

        function void check_normal(tfn_pkg::norm_item_t got);
            tfn_pkg::norm_item_t exp;
            if (pending_normals.size() == 0)
            begin
                $display("%0t: unexpected normal %h", $time, got);
                errors++;
                return;
            end
            exp = pending_normals.pop_front();
            if (got.normal_x !== exp.normal_x || got.normal_y !== exp.normal_y ||
                got.normal_z !== exp.normal_z || got.degenerate !== exp.degenerate ||
                got.end_of_mesh_out !== exp.end_of_mesh_out)
            begin
                $display("%0t: normal mismatch expected x=%0d y=%0d z=%0d deg=%b eom=%b",
                         $time, exp.normal_x, exp.normal_y, exp.normal_z,
                         exp.degenerate, exp.end_of_mesh_out);
                $display("%0t:                 actual   x=%0d y=%0d z=%0d deg=%b eom=%b",
                         $time, got.normal_x, got.normal_y, got.normal_z,
                         got.degenerate, got.end_of_mesh_out);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                tri_valid;
    logic                tri_ready;
    tfn_pkg::tri_item_t  tri_data;
    logic                norm_valid;
    logic                norm_ready;
    tfn_pkg::norm_item_t norm_data;

    normal_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;

    triangle_face_normal dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_valid  (tri_valid),
        .tri_ready  (tri_ready),
        .tri_data   (tri_data),
        .norm_valid (norm_valid),
        .norm_ready (norm_ready),
        .norm_data  (norm_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && tri_valid && tri_ready)
            board.note_triangle(tri_data);
        if (rst_n && norm_valid && norm_ready)
            board.check_normal(norm_data);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            norm_ready <= 1'b0;
        else
            norm_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic signed [tfn_pkg::COORD_W-1:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(8191)) - 4096;
            2: return {1'b0, {(tfn_pkg::COORD_W-1){1'b1}}};
            3: return {1'b1, {(tfn_pkg::COORD_W-1){1'b0}}};
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    task automatic send_triangle(tfn_pkg::tri_item_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tri_valid <= 1'b0;
            @(negedge clk);
        end
        tri_valid <= 1'b1;
        tri_data  <= t;
        @(posedge clk);
        while (!tri_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        tfn_pkg::tri_item_t t;
        int kind;
        for (int k = 0; k < count; k++)
        begin
            kind = $urandom_range(4);
            t.first_x  = rand_coord(kind);
            t.first_y  = rand_coord(kind);
            t.first_z  = rand_coord(kind);
            t.second_x = rand_coord($urandom_range(4));
            t.second_y = rand_coord(kind);
            t.second_z = rand_coord(kind);
            t.third_x  = rand_coord(kind);
            t.third_y  = rand_coord($urandom_range(4));
            t.third_z  = rand_coord(kind);
            t.end_of_mesh = $urandom_range(1);
            case ($urandom_range(9))
                0: t.third_x = t.first_x;
                1:
                begin
                    t.third_x = t.second_x;
                    t.third_y = t.second_y;
                    t.third_z = t.second_z;
                end
                default: ;
            endcase
            send_triangle(t);
        end
    endtask

    task automatic send_directed();
        logic signed [tfn_pkg::COORD_W-1:0] mx;
        logic signed [tfn_pkg::COORD_W-1:0] mn;
        tfn_pkg::tri_item_t t;
        mx = {1'b0, {(tfn_pkg::COORD_W-1){1'b1}}};
        mn = {1'b1, {(tfn_pkg::COORD_W-1){1'b0}}};
        // unit axis triangle
        t = '0;
        t.second_x = 24'sh10000;
        t.third_y  = 24'sh10000;
        send_triangle(t);
        // all vertices equal, degenerate
        t = '{mx, mx, mx, mx, mx, mx, mx, mx, mx, 1'b1};
        send_triangle(t);
        t = '{mn, mn, mn, mn, mn, mn, mn, mn, mn, 1'b0};
        send_triangle(t);
        // collinear vertices
        t = '{0, 0, 0, 1, 2, 3, 2, 4, 6, 1'b1};
        send_triangle(t);
        // widest edges
        t = '{mn, mn, mn, mx, mn, mn, mn, mx, mn, 1'b0};
        send_triangle(t);
        t = '{mx, mx, mx, mn, mx, mx, mx, mn, mx, 1'b1};
        send_triangle(t);
        t = '{mn, mx, mn, mx, mn, mx, mx, mx, mn, 1'b0};
        send_triangle(t);
        // tiny cross products
        t = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0};
        send_triangle(t);
        t = '{5, 5, 5, 6, 5, 5, 5, 5, 6, 1'b1};
        send_triangle(t);
        t = '{-1, -1, -1, 0, -1, -1, -1, -1, 0, 1'b0};
        send_triangle(t);
        // negative normals and diagonal
        t = '{0, 0, 0, 0, 24'sh10000, 0, 24'sh10000, 0, 0, 1'b0};
        send_triangle(t);
        t = '{0, 0, 0, 1, 1, 0, 0, 1, 1, 1'b1};
        send_triangle(t);
        t = '{mx, 0, mn, 0, mx, 0, mn, mn, mx, 1'b0};
        send_triangle(t);
    endtask

    task automatic drain();
        tri_valid <= 1'b0;
        while (board.pending_normals.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        #2000000;
        $display("triangle_face_normal verification failed");
        $finish;
    end

    initial
    begin
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        tri_valid = 1'b0;
        tri_data = '0;
        norm_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_directed();
        send_random(170);
        send_idle_pct = 53;
        send_random(180);
        send_idle_pct = 0;
        recv_stall_pct = 53;
        send_random(180);
        send_idle_pct = 11;
        recv_stall_pct = 11;
        send_random(200);
        drain();
        repeat (100) @(negedge clk);
        if (board.errors == 0 && board.pending_normals.size() == 0)
            $display("triangle_face_normal verification clean");
        else
            $display("triangle_face_normal verification failed");
        $finish;
    end
endmodule

@@ files.f @@
design/tfn_pkg.sv
design/tfn_sqrt_cell.sv
design/tfn_div_cell.sv
design/triangle_face_normal.sv
tb/tb_triangle_face_normal.sv
